FILE: src/tpd_pkg.sv
// Shared types and constants for the touch-pad threshold debouncer.
// No dependencies; every other file in src/ refers to this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

    localparam int NUM_PADS   = 4;
    localparam int SCAN_PADS  = 3;
    localparam int SCAN_COUNT = (SCAN_PADS < NUM_PADS) ? SCAN_PADS : NUM_PADS;
    localparam int MASK_PADS  = (NUM_PADS < 4) ? NUM_PADS : 4;

    localparam int CNT_W    = 6;
    localparam int READ_W   = 8;
    localparam int CFG_W    = 8;

    localparam logic [CNT_W-1:0]  RUN_CAP      = 6'd50;
    localparam logic [CNT_W-1:0]  SETTLE_RESET = 6'd5;
    localparam logic [READ_W-1:0] OFFSET_RESET = 8'd10;

    // Configuration register indexes
    localparam logic CFG_SETTLE = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_TICK   = 2'd1,
        OP_CAL    = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        pad;
        logic [READ_W-1:0] reading;
    } in_item_t;

    typedef struct packed {
        logic [3:0] raw_mask;
        logic [3:0] stable_mask;
        logic [3:0] struck_mask;
        logic [3:0] released_mask;
    } out_item_t;

    // Decoded command handed from the front end to the back end
    typedef struct packed {
        op_t               op;
        logic [1:0]        pad;
        logic              pad_ok;
        logic [READ_W-1:0] reading;
    } cmd_t;

endpackage

`default_nettype wire

FILE: src/tpd_front.sv
// Front end: decodes an input beat into a command and range-checks the pad.
// Depends on tpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpd_front (
    input  wire tpd_pkg::in_item_t item,
    output tpd_pkg::cmd_t          cmd
);

    always_comb
    begin
        cmd.op      = tpd_pkg::op_t'(item.func);
        cmd.pad     = item.pad;
        cmd.pad_ok  = (int'(item.pad) < tpd_pkg::NUM_PADS);
        cmd.reading = item.reading;
    end

endmodule

`default_nettype wire

FILE: src/tpd_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on tpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpd_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire tpd_pkg::cmd_t  push_cmd,
    output logic                full,
    input  wire                 pop,
    output logic                not_empty,
    output tpd_pkg::cmd_t       head
);

    tpd_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: src/tpd_back.sv
// Back end: pad state, debounce counters, config registers and result register.
// Depends on tpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpd_back (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       cfg_we,
    input  wire                       cfg_index,
    input  wire [tpd_pkg::CFG_W-1:0]  cfg_data,
    input  wire                       cmd_valid,
    input  wire tpd_pkg::cmd_t        cmd,
    output logic                      cmd_take,
    output logic                      out_valid,
    input  wire                       out_ready,
    output tpd_pkg::out_item_t        out_data
);

    localparam int NP = tpd_pkg::NUM_PADS;
    localparam int NS = tpd_pkg::SCAN_COUNT;
    localparam int CW = tpd_pkg::CNT_W;
    localparam int RW = tpd_pkg::READ_W;

    logic [CW-1:0] settle_reg;
    logic [RW-1:0] offset_reg;

    logic [RW-1:0] last_reg   [NP];
    logic [RW-1:0] last_next  [NP];
    logic [RW-1:0] thr_reg    [NP];
    logic [RW-1:0] thr_next   [NP];
    logic [NP-1:0] raw_reg,    raw_next;
    logic [NP-1:0] stable_reg, stable_next;
    logic [CW-1:0] on_reg     [NS];
    logic [CW-1:0] on_next    [NS];
    logic [CW-1:0] off_reg    [NS];
    logic [CW-1:0] off_next   [NS];
    logic [NP-1:0] struck, released;

    logic               out_valid_reg, out_valid_next;
    tpd_pkg::out_item_t out_data_reg,  out_data_next;

    assign cmd_take  = cmd_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        last_next   = last_reg;
        thr_next    = thr_reg;
        raw_next    = raw_reg;
        stable_next = stable_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        struck      = '0;
        released    = '0;

        unique case (cmd.op)
            tpd_pkg::OP_SAMPLE:
            begin
                for (int i = 0; i < NP; i++)
                begin
                    if (cmd.pad_ok && (int'(cmd.pad) == i))
                    begin
                        last_next[i] = cmd.reading;
                        raw_next[i]  = (cmd.reading < thr_reg[i]);
                    end
                end
            end
            tpd_pkg::OP_TICK:
            begin
                for (int i = 0; i < NS; i++)
                begin
                    if (raw_reg[i])
                    begin
                        off_next[i] = '0;
                        on_next[i]  = (on_reg[i] < tpd_pkg::RUN_CAP) ? on_reg[i] + 1'b1
                                                                       : on_reg[i];
                        if (!stable_reg[i] && (on_next[i] >= settle_reg))
                        begin
                            stable_next[i] = 1'b1;
                            struck[i]      = 1'b1;
                        end
                    end
                    else
                    begin
                        on_next[i]  = '0;
                        off_next[i] = (off_reg[i] < tpd_pkg::RUN_CAP) ? off_reg[i] + 1'b1
                                                                        : off_reg[i];
                        if (stable_reg[i] && (off_next[i] >= settle_reg))
                        begin
                            stable_next[i] = 1'b0;
                            released[i]    = 1'b1;
                        end
                    end
                end
            end
            tpd_pkg::OP_CAL:
            begin
                for (int i = 0; i < NP; i++)
                begin
                    thr_next[i] = last_reg[i] - offset_reg;
                end
                stable_next = '0;
            end
            tpd_pkg::OP_CLEAR:
            begin
                stable_next = '0;
            end
            default:
            begin
                stable_next = stable_reg;
            end
        endcase
    end

    // Result formatting: only pads 0..3 fit in the masks
    always_comb
    begin
        out_data_next = '0;
        for (int i = 0; i < tpd_pkg::MASK_PADS; i++)
        begin
            out_data_next.raw_mask[i]      = raw_next[i];
            out_data_next.stable_mask[i]   = stable_next[i];
            out_data_next.struck_mask[i]   = struck[i];
            out_data_next.released_mask[i] = released[i];
        end
        out_valid_next = cmd_take || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg    <= tpd_pkg::SETTLE_RESET;
            offset_reg    <= tpd_pkg::OFFSET_RESET;
            raw_reg       <= '0;
            stable_reg    <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NP; i++)
            begin
                last_reg[i] <= '0;
                thr_reg[i]  <= '0;
            end
            for (int i = 0; i < NS; i++)
            begin
                on_reg[i]  <= '0;
                off_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == tpd_pkg::CFG_SETTLE)
                begin
                    settle_reg <= cfg_data[CW-1:0];
                end
                else
                begin
                    offset_reg <= cfg_data[RW-1:0];
                end
            end
            out_valid_reg <= out_valid_next;
            if (cmd_take)
            begin
                raw_reg    <= raw_next;
                stable_reg <= stable_next;
                last_reg   <= last_next;
                thr_reg    <= thr_next;
                on_reg     <= on_next;
                off_reg    <= off_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/touch_pad_threshold_debouncer_top.sv
// An accepted beat waits in the command queue, then is registered in the result register.
// Throughput: one beat per cycle while out_ready keeps the back end's result register draining.
// The 2-entry command queue lets input keep flowing while a result waits.
// Reset (rst_n, async, low): pad readings, thresholds, raw/stable bits and
// run counters clear; settle_samples = 5, cal_offset = 10; queue and output empty.
// Depends on tpd_pkg, tpd_front, tpd_queue, tpd_back.
`timescale 1ns / 1ps
`default_nettype none

module touch_pad_threshold_debouncer_top (
    input  wire                       clk,
    input  wire                       rst_n,
    // configuration write port
    input  wire                       cfg_we,
    input  wire                       cfg_index,
    input  wire [tpd_pkg::CFG_W-1:0]  cfg_data,
    // input channel
    input  wire                       in_valid,
    output logic                      in_ready,
    input  wire tpd_pkg::in_item_t    in_data,
    // result channel
    output logic                      out_valid,
    input  wire                       out_ready,
    output tpd_pkg::out_item_t        out_data
);

    tpd_pkg::cmd_t front_cmd;
    tpd_pkg::cmd_t head_cmd;
    logic          q_full;
    logic          q_not_empty;
    logic          take;

    // Front end: classify the beat (operation, pad range check)
    tpd_front u_front (
        .item (in_data),
        .cmd  (front_cmd)
    );

    // A beat is taken whenever the queue has room, independent of the
    // result side; the queue absorbs a stalled output for a couple of beats.
    assign in_ready = !q_full;

    tpd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_cmd  (front_cmd),
        .full      (q_full),
        .pop       (take),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // Back end: state update plus result register. Pops one command per
    // cycle whenever its result register is empty or being drained.
    tpd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (q_not_empty),
        .cmd       (head_cmd),
        .cmd_take  (take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

FILE: test/tpd_mask_checker.sv
// Checker for the touch-pad debouncer: tracks config writes and input beats,
// predicts the four result masks and compares them with every result beat.
// Depends on tpd_pkg for the beat structs, op codes and register indexes.
`timescale 1ns / 1ps

module tpd_mask_checker
    import tpd_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             cfg_we,
    input  wire             cfg_index,
    input  wire [CFG_W-1:0] cfg_data,
    input  wire             in_valid,
    input  wire             in_ready,
    input  wire in_item_t   in_data,
    input  wire             out_valid,
    input  wire             out_ready,
    input  wire out_item_t  out_data,
    output int              fail_count,
    output int              pending
);

    // Shadow of the pad state
    logic [READ_W-1:0] pad_reading [NUM_PADS];
    logic [READ_W-1:0] pad_thresh  [NUM_PADS];
    logic [NUM_PADS-1:0] raw_bits;
    logic [NUM_PADS-1:0] stable_bits;
    logic [CNT_W-1:0]  touch_run [SCAN_COUNT];
    logic [CNT_W-1:0]  quiet_run [SCAN_COUNT];
    logic [CNT_W-1:0]  settle_need;
    logic [READ_W-1:0] cal_off;

    out_item_t expected_masks [$];

    function automatic out_item_t qualify_beat(input in_item_t b);
        out_item_t r;
        int i;
        r = '0;
        case (b.func)
            OP_SAMPLE:
            begin
                if (b.pad < NUM_PADS)
                begin
                    pad_reading[b.pad] = b.reading;
                    raw_bits[b.pad]    = (b.reading < pad_thresh[b.pad]);
                end
            end
            OP_TICK:
            begin
                for (i = 0; i < SCAN_COUNT; i++)
                begin
                    if (raw_bits[i])
                    begin
                        quiet_run[i] = '0;
                        if (touch_run[i] < RUN_CAP)
                            touch_run[i] = touch_run[i] + 1'b1;
                        if (!stable_bits[i] && touch_run[i] >= settle_need)
                        begin
                            stable_bits[i] = 1'b1;
                            if (i < MASK_PADS)
                                r.struck_mask[i] = 1'b1;
                        end
                    end
                    else
                    begin
                        touch_run[i] = '0;
                        if (quiet_run[i] < RUN_CAP)
                            quiet_run[i] = quiet_run[i] + 1'b1;
                        if (stable_bits[i] && quiet_run[i] >= settle_need)
                        begin
                            stable_bits[i] = 1'b0;
                            if (i < MASK_PADS)
                                r.released_mask[i] = 1'b1;
                        end
                    end
                end
            end
            OP_CAL:
            begin
                // threshold wraps modulo 256
                for (i = 0; i < NUM_PADS; i++)
                    pad_thresh[i] = pad_reading[i] - cal_off;
                stable_bits = '0;
            end
            default:
                stable_bits = '0;
        endcase
        for (i = 0; i < MASK_PADS; i++)
        begin
            r.raw_mask[i]    = raw_bits[i];
            r.stable_mask[i] = stable_bits[i];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            settle_need = SETTLE_RESET;
            cal_off     = OFFSET_RESET;
            for (int i = 0; i < NUM_PADS; i++)
            begin
                pad_reading[i] = '0;
                pad_thresh[i]  = '0;
            end
            for (int i = 0; i < SCAN_COUNT; i++)
            begin
                touch_run[i] = '0;
                quiet_run[i] = '0;
            end
            raw_bits    = '0;
            stable_bits = '0;
            expected_masks.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SETTLE)
                    settle_need = cfg_data[CNT_W-1:0];
                else
                    cal_off = cfg_data[READ_W-1:0];
            end
            if (in_valid && in_ready)
                expected_masks.push_back(qualify_beat(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_masks.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual %h",
                             $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_masks.pop_front();
                    check_field("raw_mask", want.raw_mask, out_data.raw_mask);
                    check_field("stable_mask", want.stable_mask, out_data.stable_mask);
                    check_field("struck_mask", want.struck_mask, out_data.struck_mask);
                    check_field("released_mask", want.released_mask,
                                out_data.released_mask);
                end
            end
        end
        pending = expected_masks.size();
    end

endmodule

FILE: test/touch_pad_threshold_debouncer_top_tb.sv
// Testbench top for the touch-pad debouncer: drives config writes and input
// beats, throttles the result channel and reports the verdict.
// Depends on tpd_pkg, touch_pad_threshold_debouncer_top and tpd_mask_checker.
`timescale 1ns / 1ps

module touch_pad_threshold_debouncer_top_tb;
    import tpd_pkg::*;

    // Generous cap: ~1200 beats plus drains and holds
    localparam int CYCLE_LIMIT = 200000;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_ready;
    in_item_t          in_data;
    logic              out_valid;
    logic              out_ready;
    out_item_t         out_data;

    int fail_count;
    int pending;

    // Throttle knobs, percent of cycles idle on each side
    int send_idle_pct;
    int stall_pct;
    // Long receiver hold-off, counted down by the receiver process
    int hold_cycles;
    int cycle_count = 0;

    // What the stimulus knows about the pads, used only to aim readings
    // above or below the current threshold
    logic [READ_W-1:0] shadow_level [NUM_PADS];
    logic [READ_W-1:0] shadow_thr   [NUM_PADS];
    logic [READ_W-1:0] offset_now;
    logic [CNT_W-1:0]  settle_now;

    touch_pad_threshold_debouncer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tpd_mask_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: ready changes only on the falling edge. A pending hold-off
    // wins over the random stall so the block backs up into its input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Config writes pulse cfg_we and leave an idle gap before returning, so two writes never stack.
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Build one input beat, update the stimulus shadow, then offer it.
    // Called on a falling edge and returns on a falling edge; valid stays
    // high across back-to-back beats and only drops for idle cycles.
    task automatic issue(input op_t f, input logic [1:0] p, input logic [READ_W-1:0] r);
        in_item_t b;
        int i;
        b.func    = f;
        b.pad     = p;
        b.reading = r;
        if (f == OP_SAMPLE)
            shadow_level[p] = r;
        else if (f == OP_CAL)
            for (i = 0; i < NUM_PADS; i++)
                shadow_thr[i] = shadow_level[i] - offset_now;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // Let every expected beat come back so the block is idle before a config write.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // One random phase at a fixed setting. Most traffic is touch episodes:
    // sample all pads above or below threshold on purpose, then a run of
    // scan ticks of random length, up to three past the settle count. The rest is
    // recalibration and plain noise beats.
    task automatic run_phase(input logic [CFG_W-1:0] settle_code,
                             input logic [CFG_W-1:0] offset,
                             input int idle, input int stall, input int hold,
                             input int count);
        int sent;
        int pick;
        int ticks;
        int settle_eff;
        int p;
        int k;
        logic [3:0] touch;
        logic [READ_W-1:0] thr;
        logic [READ_W-1:0] level;
        write_reg(CFG_SETTLE, settle_code);
        write_reg(CFG_OFFSET, offset);
        settle_now    = settle_code[CNT_W-1:0];
        offset_now    = offset;
        send_idle_pct = idle;
        stall_pct     = stall;
        hold_cycles   = hold;
        // settle of zero acts as one; above fifty the counters saturate first
        settle_eff = (settle_now == 0) ? 1 : ((settle_now > RUN_CAP) ? 52 : settle_now);
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                for (p = 0; p < NUM_PADS; p++)
                    issue(OP_SAMPLE, 2'(p), 8'($urandom));
                issue(OP_CAL, 2'($urandom), 8'($urandom));
                sent += NUM_PADS + 1;
            end
            else if (pick < 18)
            begin
                issue(op_t'($urandom_range(3)), 2'($urandom), 8'($urandom));
                sent++;
            end
            else
            begin
                touch = 4'($urandom);
                for (p = 0; p < NUM_PADS; p++)
                begin
                    thr = shadow_thr[p];
                    if (touch[p] && thr != 0)
                        level = 8'($urandom_range(thr - 1, 0));
                    else if (!touch[p])
                        level = 8'($urandom_range(255, thr));
                    else
                        level = 8'($urandom);
                    issue(OP_SAMPLE, 2'(p), level);
                end
                ticks = $urandom_range(1, settle_eff + 3);
                for (k = 0; k < ticks; k++)
                begin
                    // an occasional clear mid-run: counters keep going
                    if ($urandom_range(99) < 4)
                        issue(OP_CLEAR, 2'($urandom), 8'($urandom));
                    else
                        issue(OP_TICK, 2'($urandom), 8'($urandom));
                end
                sent += NUM_PADS + ticks;
            end
        end
        drain();
    endtask

    initial
    begin
        cfg_we        = 1'b0;
        cfg_index     = CFG_SETTLE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_cycles   = 0;
        offset_now    = OFFSET_RESET;
        settle_now    = SETTLE_RESET;
        for (int i = 0; i < NUM_PADS; i++)
        begin
            shadow_level[i] = '0;
            shadow_thr[i]   = '0;
        end
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, reset settings (settle 5, offset 10).
        // Uncalibrated pads: threshold is zero, so even a reading of 0 is not
        // a touch. Pad 3 is sampled but lies outside the scan.
        issue(OP_SAMPLE, 2'd0, 8'd0);
        issue(OP_SAMPLE, 2'd1, 8'd255);
        issue(OP_SAMPLE, 2'd2, 8'd128);
        issue(OP_SAMPLE, 2'd3, 8'd5);
        issue(OP_TICK, 2'd0, 8'd0);
        // Calibrate: 0-10 and 5-10 wrap to 246 and 251
        issue(OP_CAL, 2'd0, 8'd0);
        // Pad 0 just under its threshold, pad 1 at the top, pad 2 at zero,
        // pad 3 touched but never debounced
        issue(OP_SAMPLE, 2'd0, 8'd245);
        issue(OP_SAMPLE, 2'd1, 8'd255);
        issue(OP_SAMPLE, 2'd2, 8'd0);
        issue(OP_SAMPLE, 2'd3, 8'd250);
        // fifth tick strikes pads 0 and 2
        repeat (5) issue(OP_TICK, 2'd3, 8'd255);
        // release pad 0 after five quiet ticks
        issue(OP_SAMPLE, 2'd0, 8'd255);
        repeat (5) issue(OP_TICK, 2'd1, 8'd17);
        // Clear keeps raw bits and counters: the next tick strikes pad 2 again
        issue(OP_CLEAR, 2'd2, 8'd170);
        issue(OP_TICK, 2'd0, 8'd85);
        drain();

        // Random phases. Register extremes: settle 1 and 50, a raw 0 (acts
        // like 1), 0xFF (masks to 63, stable state frozen); offset 0 and 255.
        // First phase runs flat out with a long receiver hold-off so the
        // input side backs up.
        run_phase(8'd1,   8'd0,   0,  0,  60, 200);
        run_phase(8'd50,  8'd255, 71, 0,  0,  200);
        run_phase(8'd3,   8'd40,  0,  71, 0,  200);
        run_phase(8'd0,   8'd128, 23, 23, 0,  200);
        run_phase(8'hFF,  8'd1,   0,  0,  0,  150);
        run_phase(8'd12,  8'd10,  23, 23, 0,  200);

        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: touch_pad_threshold_debouncer_top.f
src/tpd_pkg.sv
src/tpd_front.sv
src/tpd_queue.sv
src/tpd_back.sv
src/touch_pad_threshold_debouncer_top.sv
test/tpd_mask_checker.sv
test/touch_pad_threshold_debouncer_top_tb.sv
